/* rtl/core/jfbe_pkg.sv */
package jfbe_pkg;

    localparam int HISTORY_DEPTH = 4;

    localparam int AXIS_W   = 11;
    localparam int DIFF_W   = AXIS_W + 1;
    localparam int SQ_W     = 22;          // 2047^2 fits in 22 bits
    localparam int RAD_W    = 24;          // sum of two squares, padded to even
    localparam int ROOT_W   = RAD_W / 2;
    localparam int REM_W    = ROOT_W + 1;
    localparam int SQ_STEPS = ROOT_W;
    localparam int SQ_CNT_W = $clog2(SQ_STEPS + 1);
    localparam int BTN_W    = 5;
    localparam int REG_W    = 10;
    localparam int DIR_W    = 3;
    localparam int SPEED_W  = 12;
    localparam int CFG_IDX_W = 1;

    localparam logic [REG_W-1:0] DEADZONE_RST = REG_W'(200);
    localparam logic [REG_W-1:0] DIR_THR_RST  = REG_W'(707);

    localparam logic [CFG_IDX_W-1:0] REG_DEADZONE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_THR  = 1'b1;

    typedef enum logic [DIR_W-1:0] {
        DIR_NEUTRAL = 3'd0,
        DIR_RIGHT   = 3'd1,
        DIR_LEFT    = 3'd2,
        DIR_DOWN    = 3'd3,
        DIR_UP      = 3'd4
    } t_dir;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WIN,
        ST_SQR,
        ST_SUM,
        ST_START1,
        ST_WAIT1,
        ST_START2,
        ST_WAIT2,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic signed [AXIS_W-1:0] x;
        logic signed [AXIS_W-1:0] y;
    } t_stick;

    typedef struct packed {
        t_stick             left;
        t_stick             right;
        logic [BTN_W-1:0]   buttons;
        logic               use_old;
    } t_sample;

    typedef struct packed {
        logic [BTN_W-1:0]   pressed_mask;
        logic [BTN_W-1:0]   released_mask;
        logic [DIR_W-1:0]   move_direction;
        logic [DIR_W-1:0]   attack_direction;
        logic [DIR_W-1:0]   push_direction;
        logic [DIR_W-1:0]   flick_direction;
        logic               hard_push;
        logic [SPEED_W-1:0] flick_speed;
    } t_result;

    typedef struct packed {
        logic cap;        // latch incoming request
        logic win;        // form step differences
        logic sqr;        // square the differences
        logic sum;        // add squares per step
        logic sq_start;   // launch root unit
        logic sq_sel;     // 0: newer step, 1: older step
        logic d1_load;    // keep first root
        logic fin;        // commit result and history
    } t_cmd;

    typedef struct packed {
        logic sq_busy;
        logic out_hold;
    } t_sts;

    // five-way direction, x tested before y
    function automatic t_dir dir_of(t_stick s, logic [REG_W-1:0] thr);
        logic signed [DIFF_W-1:0] t;
        logic signed [DIFF_W-1:0] xe;
        logic signed [DIFF_W-1:0] ye;
        t_dir d;
        t  = $signed({2'b00, thr});
        xe = $signed({s.x[AXIS_W-1], s.x});
        ye = $signed({s.y[AXIS_W-1], s.y});
        if (xe > t) begin
            d = DIR_RIGHT;
        end else if (xe < -t) begin
            d = DIR_LEFT;
        end else if (ye > t) begin
            d = DIR_DOWN;
        end else if (ye < -t) begin
            d = DIR_UP;
        end else begin
            d = DIR_NEUTRAL;
        end
        return d;
    endfunction

endpackage

/* rtl/core/jfbe_in_if.sv */
interface jfbe_in_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [jfbe_pkg::AXIS_W-1:0]     left_x;
    logic signed [jfbe_pkg::AXIS_W-1:0]     left_y;
    logic signed [jfbe_pkg::AXIS_W-1:0]     right_x;
    logic signed [jfbe_pkg::AXIS_W-1:0]     right_y;
    logic [jfbe_pkg::BTN_W-1:0]             buttons;
    logic                                   use_old;

    modport source (
        output valid, left_x, left_y, right_x, right_y, buttons, use_old,
        input  ready
    );
    modport sink (
        input  valid, left_x, left_y, right_x, right_y, buttons, use_old,
        output ready
    );
endinterface

/* rtl/core/jfbe_out_if.sv */
interface jfbe_out_if;
    logic                               valid;
    logic                               ready;
    logic [jfbe_pkg::BTN_W-1:0]         pressed_mask;
    logic [jfbe_pkg::BTN_W-1:0]         released_mask;
    logic [jfbe_pkg::DIR_W-1:0]         move_direction;
    logic [jfbe_pkg::DIR_W-1:0]         attack_direction;
    logic [jfbe_pkg::DIR_W-1:0]         push_direction;
    logic [jfbe_pkg::DIR_W-1:0]         flick_direction;
    logic                               hard_push;
    logic [jfbe_pkg::SPEED_W-1:0]       flick_speed;

    modport source (
        output valid, pressed_mask, released_mask, move_direction, attack_direction,
               push_direction, flick_direction, hard_push, flick_speed,
        input  ready
    );
    modport sink (
        input  valid, pressed_mask, released_mask, move_direction, attack_direction,
               push_direction, flick_direction, hard_push, flick_speed,
        output ready
    );
endinterface

/* rtl/core/jfbe_isqrt.sv */
module jfbe_isqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [jfbe_pkg::RAD_W-1:0]    i_radicand,
    output logic                          o_busy,
    output logic [jfbe_pkg::ROOT_W-1:0]   o_root
);

    localparam int RW = jfbe_pkg::REM_W;
    localparam int QW = jfbe_pkg::ROOT_W;

    logic                            r_busy, n_busy;
    logic [jfbe_pkg::SQ_CNT_W-1:0]   r_cnt, n_cnt;
    logic [jfbe_pkg::RAD_W-1:0]      r_rad, n_rad;
    logic [RW-1:0]                   r_rem, n_rem;
    logic [QW-1:0]                   r_root, n_root;

    logic [RW+1:0] rem_sh;
    logic [RW+1:0] trial;

    // two radicand bits per cycle, restoring
    always_comb begin
        rem_sh = {r_rem, r_rad[jfbe_pkg::RAD_W-1 -: 2]};
        trial  = (RW+2)'({r_root, 2'b01});
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_rad  = r_rad;
        n_rem  = r_rem;
        n_root = r_root;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = jfbe_pkg::SQ_CNT_W'(jfbe_pkg::SQ_STEPS);
            n_rad  = i_radicand;
            n_rem  = '0;
            n_root = '0;
        end else if (r_busy) begin
            n_rad = {r_rad[jfbe_pkg::RAD_W-3:0], 2'b00};
            if (rem_sh >= trial) begin
                n_rem  = RW'(rem_sh - trial);
                n_root = {r_root[QW-2:0], 1'b1};
            end else begin
                n_rem  = RW'(rem_sh);
                n_root = {r_root[QW-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == jfbe_pkg::SQ_CNT_W'(1)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_rad  <= n_rad;
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    assign o_busy = r_busy;
    assign o_root = r_root;

endmodule

/* rtl/core/jfbe_ctrl.sv */
module jfbe_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  jfbe_pkg::t_sts i_sts,
    output jfbe_pkg::t_cmd o_cmd
);

    jfbe_pkg::t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            jfbe_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = jfbe_pkg::ST_WIN;
            end
            jfbe_pkg::ST_WIN:    n_state = jfbe_pkg::ST_SQR;
            jfbe_pkg::ST_SQR:    n_state = jfbe_pkg::ST_SUM;
            jfbe_pkg::ST_SUM:    n_state = jfbe_pkg::ST_START1;
            jfbe_pkg::ST_START1: n_state = jfbe_pkg::ST_WAIT1;
            jfbe_pkg::ST_WAIT1: begin
                if (!i_sts.sq_busy) n_state = jfbe_pkg::ST_START2;
            end
            jfbe_pkg::ST_START2: n_state = jfbe_pkg::ST_WAIT2;
            jfbe_pkg::ST_WAIT2: begin
                if (!i_sts.sq_busy) n_state = jfbe_pkg::ST_DONE;
            end
            jfbe_pkg::ST_DONE: begin
                if (!i_sts.out_hold) n_state = jfbe_pkg::ST_IDLE;
            end
            default: n_state = jfbe_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            jfbe_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.cap  = i_in_valid;
            end
            jfbe_pkg::ST_WIN:    o_cmd.win = 1'b1;
            jfbe_pkg::ST_SQR:    o_cmd.sqr = 1'b1;
            jfbe_pkg::ST_SUM:    o_cmd.sum = 1'b1;
            jfbe_pkg::ST_START1: o_cmd.sq_start = 1'b1;
            jfbe_pkg::ST_WAIT1:  o_cmd.d1_load = !i_sts.sq_busy;
            jfbe_pkg::ST_START2: begin
                o_cmd.sq_start = 1'b1;
                o_cmd.sq_sel   = 1'b1;
            end
            jfbe_pkg::ST_WAIT2:  o_cmd.sq_sel = 1'b1;
            jfbe_pkg::ST_DONE:   o_cmd.fin = !i_sts.out_hold;
            default: begin
                o_cmd      = '0;
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= jfbe_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* rtl/core/jfbe_dp.sv */
module jfbe_dp #(
    parameter int HISTORY_DEPTH = jfbe_pkg::HISTORY_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [jfbe_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [jfbe_pkg::REG_W-1:0]        i_cfg_data,
    input  jfbe_pkg::t_sample                 i_sample,
    input  jfbe_pkg::t_cmd                    i_cmd,
    output jfbe_pkg::t_sts                    o_sts,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output jfbe_pkg::t_result                 o_res
);

    localparam int HIST_LEN = HISTORY_DEPTH - 1;
    localparam int DW = jfbe_pkg::DIFF_W;

    logic [jfbe_pkg::REG_W-1:0]     r_deadzone;
    logic [jfbe_pkg::REG_W-1:0]     r_dir_thr;
    jfbe_pkg::t_stick               r_hist [HIST_LEN];
    logic [jfbe_pkg::BTN_W-1:0]     r_last_btn;
    jfbe_pkg::t_sample              r_cur;
    logic signed [DW-1:0]           r_diff [4];
    logic [jfbe_pkg::SQ_W-1:0]      r_sq [4];
    logic [jfbe_pkg::SQ_W:0]        r_s1, r_s2;
    logic [jfbe_pkg::ROOT_W-1:0]    r_d1;
    logic                           r_out_vld;
    jfbe_pkg::t_result              r_res;

    logic                           use_sel;
    jfbe_pkg::t_stick               nj, o0, o1;
    logic signed [DW-1:0]           diff [4];
    logic signed [2*DW-1:0]         prod [4];
    logic [jfbe_pkg::RAD_W-1:0]     radicand;
    logic                           sq_busy;
    logic [jfbe_pkg::ROOT_W-1:0]    root;
    jfbe_pkg::t_dir                 mdir, fdir, rdir, hdir;
    logic signed [DW-1:0]           dz, o0x, o0y;
    logic                           hard;
    logic [jfbe_pkg::ROOT_W:0]      speed_sum;
    jfbe_pkg::t_result              res;

    // fallback window when the stick sat still
    always_comb begin
        use_sel = r_cur.use_old && (r_cur.left == r_hist[0]);
        nj = use_sel ? r_hist[0] : r_cur.left;
        o0 = use_sel ? r_hist[1] : r_hist[0];
        o1 = use_sel ? r_hist[2] : r_hist[1];
        diff[0] = $signed({nj.x[jfbe_pkg::AXIS_W-1], nj.x})
                - $signed({o0.x[jfbe_pkg::AXIS_W-1], o0.x});
        diff[1] = $signed({nj.y[jfbe_pkg::AXIS_W-1], nj.y})
                - $signed({o0.y[jfbe_pkg::AXIS_W-1], o0.y});
        diff[2] = $signed({o0.x[jfbe_pkg::AXIS_W-1], o0.x})
                - $signed({o1.x[jfbe_pkg::AXIS_W-1], o1.x});
        diff[3] = $signed({o0.y[jfbe_pkg::AXIS_W-1], o0.y})
                - $signed({o1.y[jfbe_pkg::AXIS_W-1], o1.y});
        for (int k = 0; k < 4; k++) begin
            prod[k] = r_diff[k] * r_diff[k];
        end
    end

    assign radicand = i_cmd.sq_sel ? jfbe_pkg::RAD_W'(r_s2) : jfbe_pkg::RAD_W'(r_s1);

    jfbe_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.sq_start),
        .i_radicand (radicand),
        .o_busy     (sq_busy),
        .o_root     (root)
    );

    always_comb begin
        mdir = jfbe_pkg::dir_of(r_cur.left, r_dir_thr);
        rdir = jfbe_pkg::dir_of(r_cur.right, r_dir_thr);
        fdir = jfbe_pkg::dir_of(nj, r_dir_thr);
        hdir = jfbe_pkg::dir_of(r_hist[0], r_dir_thr);
        dz   = $signed({2'b00, r_deadzone});
        o0x  = $signed({o0.x[jfbe_pkg::AXIS_W-1], o0.x});
        o0y  = $signed({o0.y[jfbe_pkg::AXIS_W-1], o0.y});
        case (fdir)
            jfbe_pkg::DIR_RIGHT: hard = (o0x < dz);
            jfbe_pkg::DIR_LEFT:  hard = (o0x > -dz);
            jfbe_pkg::DIR_DOWN:  hard = (o0y < dz);
            jfbe_pkg::DIR_UP:    hard = (o0y > -dz);
            default:             hard = 1'b0;
        endcase
        speed_sum = {1'b0, r_d1} + {1'b0, root};

        res.pressed_mask     = r_cur.buttons & ~r_last_btn;
        res.released_mask    = ~r_cur.buttons & r_last_btn;
        res.move_direction   = mdir;
        res.attack_direction = rdir;
        res.push_direction   = (hdir == jfbe_pkg::DIR_NEUTRAL) ? mdir : jfbe_pkg::DIR_NEUTRAL;
        res.flick_direction  = fdir;
        res.hard_push        = hard;
        res.flick_speed      = speed_sum[jfbe_pkg::ROOT_W:1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadzone <= jfbe_pkg::DEADZONE_RST;
            r_dir_thr  <= jfbe_pkg::DIR_THR_RST;
            r_last_btn <= '0;
            r_out_vld  <= 1'b0;
            for (int k = 0; k < HIST_LEN; k++) begin
                r_hist[k] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    jfbe_pkg::REG_DEADZONE: r_deadzone <= i_cfg_data;
                    jfbe_pkg::REG_DIR_THR:  r_dir_thr  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.fin) begin
                r_out_vld  <= 1'b1;
                r_last_btn <= r_cur.buttons;
                for (int k = HIST_LEN - 1; k > 0; k--) begin
                    r_hist[k] <= r_hist[k-1];
                end
                r_hist[0] <= r_cur.left;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
        if (i_cmd.cap) r_cur <= i_sample;
        if (i_cmd.win) begin
            for (int k = 0; k < 4; k++) r_diff[k] <= diff[k];
        end
        if (i_cmd.sqr) begin
            for (int k = 0; k < 4; k++) r_sq[k] <= jfbe_pkg::SQ_W'(prod[k]);
        end
        if (i_cmd.sum) begin
            r_s1 <= {1'b0, r_sq[0]} + {1'b0, r_sq[1]};
            r_s2 <= {1'b0, r_sq[2]} + {1'b0, r_sq[3]};
        end
        if (i_cmd.d1_load) r_d1 <= root;
        if (i_cmd.fin) r_res <= res;
    end

    assign o_sts.sq_busy  = sq_busy;
    assign o_sts.out_hold = r_out_vld && !i_out_ready;
    assign o_out_valid    = r_out_vld;
    assign o_res          = r_res;

endmodule

/* rtl/core/joystick_flick_and_button_edge.sv */
// channel | dir | handshake       | payload
// i_in    | in  | valid / ready   | left_x, left_y, right_x, right_y, buttons, use_old
// o_out   | out | valid / ready   | masks, four directions, hard_push, flick_speed
// i_cfg   | in  | i_cfg_we        | i_cfg_idx, i_cfg_data (no read-back)
//
// A request runs through capture, step differences, squares and sums, then two
// passes of the shared bit-pair square root unit.
// The root unit is the only long path and sets the per-request time.
// i_rst_n is synchronous: history, last buttons and control clear, registers reload.
// A stalled result sits in the output register; the next request is taken while it
// waits and parks in the final state until the register frees up.
module joystick_flick_and_button_edge #(
    parameter int HISTORY_DEPTH = jfbe_pkg::HISTORY_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    jfbe_in_if.sink                           i_in,
    jfbe_out_if.source                        o_out,
    input  logic                              i_cfg_we,
    input  logic [jfbe_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [jfbe_pkg::REG_W-1:0]        i_cfg_data
);

    jfbe_pkg::t_cmd    cmd;
    jfbe_pkg::t_sts    sts;
    jfbe_pkg::t_sample sample;
    jfbe_pkg::t_result res;
    logic              in_ready;
    logic              out_valid;

    // flatten the request into the datapath sample record
    assign sample.left.x  = i_in.left_x;
    assign sample.left.y  = i_in.left_y;
    assign sample.right.x = i_in.right_x;
    assign sample.right.y = i_in.right_y;
    assign sample.buttons = i_in.buttons;
    assign sample.use_old = i_in.use_old;

    jfbe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    jfbe_dp #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_sample    (sample),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_ready (o_out.ready),
        .o_out_valid (out_valid),
        .o_res       (res)
    );

    assign i_in.ready             = in_ready;
    assign o_out.valid            = out_valid;
    assign o_out.pressed_mask     = res.pressed_mask;
    assign o_out.released_mask    = res.released_mask;
    assign o_out.move_direction   = res.move_direction;
    assign o_out.attack_direction = res.attack_direction;
    assign o_out.push_direction   = res.push_direction;
    assign o_out.flick_direction  = res.flick_direction;
    assign o_out.hard_push        = res.hard_push;
    assign o_out.flick_speed      = res.flick_speed;

    // a taken request closes the input until its result is committed
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && in_ready) |=> !in_ready)
        else $error("input reopened while a request is in flight");

    // commit only after the root unit has finished both passes
    a_fin_after_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.fin |-> !sts.sq_busy)
        else $error("result committed while root unit busy");

    // a commit always shows up at the output on the next edge
    a_fin_to_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.fin |=> out_valid)
        else $error("committed result not presented");

    // capture never overlaps a running root pass
    a_cap_idle_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.cap |-> !sts.sq_busy)
        else $error("request captured while root unit busy");

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

// Gamepad front end testbench: button edges, five-way stick directions, push
// direction, flick speed and the hard-push flag.
// Every accepted request is run through a local predictor. The predicted frame
// is queued, and each result taken from the output channel is checked field by
// field against the oldest queued frame.
module tb_top;
    import jfbe_pkg::*;

    localparam int HALF_PERIOD   = 4;
    localparam int RESET_CYCLES  = 10;
    localparam int MAX_GAP       = 19;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 300;        // long receiver hold-off
    localparam int TIMEOUT_NS    = 5_000_000;
    localparam int HIST_LEN      = HISTORY_DEPTH - 1;
    localparam int MAX_REPORTS   = 50;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [REG_W-1:0]     i_cfg_data;

    jfbe_in_if  in_if ();
    jfbe_out_if out_if ();

    joystick_flick_and_button_edge #(
        .HISTORY_DEPTH(HISTORY_DEPTH)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (in_if),
        .o_out     (out_if),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor state: its own copy of the registers, the left-stick
    // history (newest first) and the buttons of the previous request.
    // ------------------------------------------------------------------
    logic [REG_W-1:0] cfg_dz;
    logic [REG_W-1:0] cfg_thr;
    int               hist_x [HIST_LEN];
    int               hist_y [HIST_LEN];
    logic [BTN_W-1:0] prev_buttons;

    t_result expected_frames [$];
    t_stick  last_left;             // left stick of the last request sent

    // side control
    bit tx_idle_en;
    bit rx_idle_en;
    int rx_gap;                     // cycles ready stays low before the next result
    int rx_hold_cycles;             // one-shot long hold-off request

    // bookkeeping
    int err_count;
    int frames_sent;
    int frames_checked;
    int settings_used;
    int fallback_hits;
    int hard_hits;

    // Five-way direction. x is tested before y, strictly beyond the threshold.
    function automatic t_dir stick_dir(int x, int y);
        int thr;
        thr = int'(cfg_thr);
        if (x > thr)  return DIR_RIGHT;
        if (x < -thr) return DIR_LEFT;
        if (y > thr)  return DIR_DOWN;
        if (y < -thr) return DIR_UP;
        return DIR_NEUTRAL;
    endfunction

    // floor(sqrt(n)); the real estimate is nudged to the exact integer root
    function automatic int floor_root(int n);
        int r;
        r = int'($sqrt(real'(n)));
        while (r * r > n) r--;
        while ((r + 1) * (r + 1) <= n) r++;
        return r;
    endfunction

    function automatic int step_len(int ax, int ay, int bx, int by);
        return floor_root((ax - bx) * (ax - bx) + (ay - by) * (ay - by));
    endfunction

    // Expected frame for one request; also advances the predictor state.
    function automatic t_result predict_frame(t_sample s);
        t_result r;
        int      cx, cy, rx, ry;
        int      nx, ny, ox, oy, px, py;   // newest, older, oldest of the window
        int      dz;
        t_dir    md, fd;
        logic    hard;

        cx = s.left.x;
        cy = s.left.y;
        rx = s.right.x;
        ry = s.right.y;
        dz = int'(cfg_dz);
        md = stick_dir(cx, cy);

        nx = cx;
        ny = cy;
        ox = hist_x[0];
        oy = hist_y[0];
        px = hist_x[1];
        py = hist_y[1];
        // unmoved stick with use_old: slide the window back one sample
        if (s.use_old && cx == hist_x[0] && cy == hist_y[0]) begin
            nx = hist_x[0];
            ny = hist_y[0];
            ox = hist_x[1];
            oy = hist_y[1];
            px = hist_x[2];
            py = hist_y[2];
            fallback_hits++;
        end

        fd = stick_dir(nx, ny);
        case (fd)
            DIR_RIGHT: begin
                hard = (ox < dz);
            end
            DIR_LEFT: begin
                hard = (ox > -dz);
            end
            DIR_DOWN: begin
                hard = (oy < dz);
            end
            DIR_UP: begin
                hard = (oy > -dz);
            end
            default: begin
                hard = 1'b0;
            end
        endcase
        if (hard) hard_hits++;

        r.pressed_mask     = s.buttons & ~prev_buttons;
        r.released_mask    = ~s.buttons & prev_buttons;
        r.move_direction   = md;
        r.attack_direction = stick_dir(rx, ry);
        r.push_direction   = (stick_dir(hist_x[0], hist_y[0]) == DIR_NEUTRAL) ? md : DIR_NEUTRAL;
        r.flick_direction  = fd;
        r.hard_push        = hard;
        r.flick_speed      = SPEED_W'((step_len(nx, ny, ox, oy) + step_len(ox, oy, px, py)) >> 1);

        for (int i = HIST_LEN - 1; i > 0; i--) begin
            hist_x[i] = hist_x[i - 1];
            hist_y[i] = hist_y[i - 1];
        end
        hist_x[0]    = cx;
        hist_y[0]    = cy;
        prev_buttons = s.buttons;
        return r;
    endfunction

    // Axis value mix: broad sweep, threshold edges, deadzone, extremes, raw 11 bit.
    function automatic int rand_axis();
        int sel;
        int sgn;
        sel = $urandom_range(0, 99);
        sgn = $urandom_range(0, 1) ? 1 : -1;
        if (sel < 40) return int'($urandom_range(0, 2000)) - 1000;
        if (sel < 60) return sgn * (int'(cfg_thr) + int'($urandom_range(0, 4)) - 2);
        if (sel < 72) return int'($urandom_range(0, 2 * cfg_dz)) - int'(cfg_dz);
        if (sel < 82) return sgn * 1000;
        if (sel < 88) return int'($urandom_range(0, 2047)) - 1024;
        return 0;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        err_count++;
        if (err_count <= MAX_REPORTS) begin
            $display("[%0t] frame %0d: %s got %0d want %0d",
                     $time, frames_checked, what, got, want);
        end
    endtask

    // ------------------------------------------------------------------
    // Request side. Called at a falling edge; returns at the falling edge
    // after acceptance with valid still high, so a back-to-back request
    // only updates the payload.
    // ------------------------------------------------------------------
    task automatic send_sample(input t_sample s);
        int gap;
        gap = tx_idle_en ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.left_x  <= s.left.x;
        in_if.left_y  <= s.left.y;
        in_if.right_x <= s.right.x;
        in_if.right_y <= s.right.y;
        in_if.buttons <= s.buttons;
        in_if.use_old <= s.use_old;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        expected_frames.push_back(predict_frame(s));
        frames_sent++;
        last_left = s.left;
        @(negedge i_clk);
    endtask

    task automatic send_fixed(int lx, int ly, int rx, int ry, int btn, bit uo);
        t_sample s;
        s.left.x  = lx[AXIS_W-1:0];
        s.left.y  = ly[AXIS_W-1:0];
        s.right.x = rx[AXIS_W-1:0];
        s.right.y = ry[AXIS_W-1:0];
        s.buttons = btn[BTN_W-1:0];
        s.use_old = uo;
        send_sample(s);
    endtask

    // left stick given, right stick and buttons random
    task automatic send_left(int lx, int ly, bit uo);
        send_fixed(lx, ly, rand_axis(), rand_axis(), $urandom_range(0, 31), uo);
    endtask

    // Drop valid, wait for every queued frame, then let the pipe settle.
    task automatic drain(int settle);
        in_if.valid <= 1'b0;
        while (expected_frames.size() != 0) @(negedge i_clk);
        repeat (settle) @(negedge i_clk);
    endtask

    // Both registers in back-to-back cycles; only called with the block idle.
    task automatic set_registers(int dz, int thr);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_DEADZONE;
        i_cfg_data <= dz[REG_W-1:0];
        @(negedge i_clk);
        i_cfg_idx  <= REG_DIR_THR;
        i_cfg_data <= thr[REG_W-1:0];
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        cfg_dz  = dz[REG_W-1:0];
        cfg_thr = thr[REG_W-1:0];
        settings_used++;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset registers (deadzone 200, threshold 707), history starts neutral.
    task automatic test_directed_edges();
        send_fixed(0, 0, 0, 0, 5'h1F, 0);            // every button pressed
        send_fixed(708, 0, 708, 0, 5'h00, 0);        // all released, just past threshold
        send_fixed(707, 800, -708, 0, 5'h0A, 0);     // x at threshold falls to y: down
        send_fixed(-1000, -1000, 0, 708, 5'h15, 0);  // x wins over y
        send_fixed(-1000, -1000, 0, -708, 5'h15, 1); // unmoved with use_old: fallback
        send_fixed(-1000, -1000, 0, 0, 5'h0A, 0);    // unmoved, no fallback
        send_fixed(0, -708, 0, -708, 5'h1F, 0);      // up on both sticks
        send_fixed(1023, 1023, -1024, -1024, 0, 0);  // beyond nominal range
        send_fixed(-1024, 0, 1023, 0, 5'h11, 0);
        send_fixed(0, 0, -707, 707, 5'h0E, 0);       // right stick on the edge: neutral
        send_fixed(0, 0, 0, 0, 5'h0E, 1);            // fallback with the newest window sample neutral
        send_fixed(1000, 0, 0, 0, 5'h01, 0);         // hard push from rest
        send_fixed(1000, 300, 0, 0, 5'h02, 0);       // older sample outside deadzone
        send_fixed(0, 1000, 0, 0, 5'h04, 0);
        send_fixed(-199, 0, 0, 0, 5'h08, 0);
        send_fixed(-1000, 0, 0, 0, 5'h10, 0);        // just inside deadzone: hard
        send_fixed(-200, 0, 0, 0, 5'h10, 0);
        send_fixed(-1000, 0, 0, 0, 5'h00, 0);        // on the deadzone edge: not hard
        send_fixed(0, -200, 0, 0, 5'h1F, 0);
        send_fixed(0, -1000, 0, 0, 5'h1F, 0);
        send_fixed(0, 199, 0, 0, 5'h00, 0);
        send_fixed(0, 1000, 0, 0, 5'h00, 0);
        send_fixed(0, 1000, 0, 0, 5'h00, 1);         // held push, window slides back
        drain(SETTLE_CYCLES);
    endtask

    task automatic test_register_extremes();
        // zero threshold: any nonzero component is a direction
        set_registers(0, 0);
        send_left(1, 0, 0);
        send_left(0, -1, 0);
        send_left(0, 1, 0);
        send_left(-1, 0, 0);
        send_left(0, 0, 1);
        drain(SETTLE_CYCLES);
        // all-ones registers, beyond the nominal range
        set_registers(1023, 1023);
        send_fixed(1023, 1023, -1024, -1024, 5'h1F, 0);
        send_left(-1024, 0, 0);
        send_left(0, -1024, 0);
        send_left(1022, -1023, 0);
        drain(SETTLE_CYCLES);
        set_registers(1000, 1000);
        send_left(1000, 0, 0);
        send_left(1001, 0, 0);
        send_left(0, -1001, 0);
        drain(SETTLE_CYCLES);
    endtask

    // Mostly flick gestures (rest, optional midpoint, push, hold), plus noise
    // and repeated sticks. Runs through several register settings.
    task automatic test_random_gestures(int per_phase);
        int dz_set  [5];
        int thr_set [5];
        int stop_at;
        int kind;
        int mag;
        int tx, ty;
        bit on_x;
        dz_set  = '{200, 0, 1023, 0, 0};
        thr_set = '{707, 0, 1023, 0, 0};
        for (int p = 0; p < 5; p++) begin
            if (p >= 3) begin
                dz_set[p]  = $urandom_range(0, 1000);
                thr_set[p] = $urandom_range(0, 1000);
            end
            set_registers(dz_set[p], thr_set[p]);
            stop_at = frames_sent + per_phase;
            while (frames_sent < stop_at) begin
                kind = $urandom_range(0, 9);
                if (kind < 6) begin
                    mag  = (cfg_thr < 1000) ? $urandom_range(1000, cfg_thr + 1) : 1023;
                    mag  = $urandom_range(0, 1) ? mag : -mag;
                    on_x = $urandom_range(0, 1);
                    tx   = on_x ? mag : int'($urandom_range(0, 2 * cfg_dz)) - int'(cfg_dz);
                    ty   = on_x ? int'($urandom_range(0, 2 * cfg_dz)) - int'(cfg_dz) : mag;
                    send_left(int'($urandom_range(0, 2 * cfg_dz)) - int'(cfg_dz),
                              int'($urandom_range(0, 2 * cfg_dz)) - int'(cfg_dz),
                              $urandom_range(0, 1));
                    if (kind == 0) send_left(tx / 2, ty / 2, $urandom_range(0, 1));
                    send_left(tx, ty, $urandom_range(0, 1));
                    repeat ($urandom_range(0, 2)) send_left(tx, ty, $urandom_range(0, 3) != 0);
                end else if (kind < 8) begin
                    send_left(rand_axis(), rand_axis(), $urandom_range(0, 1));
                end else begin
                    send_left(last_left.x, last_left.y, $urandom_range(0, 1));
                end
            end
            drain(SETTLE_CYCLES);
        end
    endtask

    // Receiver holds off while requests keep coming: output register and the
    // parked request fill, then the input must stall.
    task automatic test_output_backpressure();
        tx_idle_en     = 1'b0;
        rx_hold_cycles = HOLD_CYCLES;
        repeat (20) send_left(rand_axis(), rand_axis(), $urandom_range(0, 1));
        tx_idle_en = 1'b1;
        drain(SETTLE_CYCLES);
    endtask

    // Neither side idles.
    task automatic test_full_rate();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        repeat (50) send_left(rand_axis(), rand_axis(), $urandom_range(0, 1));
        drain(SETTLE_CYCLES);
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Result side: ready is driven at the falling edge, low for the drawn
    // gap after each result (or for a requested long hold-off).
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (rx_hold_cycles > 0) begin
            rx_gap         = rx_hold_cycles;
            rx_hold_cycles = 0;
        end
        if (rx_gap > 0) begin
            out_if.ready <= 1'b0;
            rx_gap--;
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    // Check each accepted result against the oldest predicted frame.
    always @(posedge i_clk) begin : check_proc
        t_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            rx_gap = rx_idle_en ? $urandom_range(0, MAX_GAP) : 0;
            if (expected_frames.size() == 0) begin
                report_mismatch("result with nothing expected", out_if.flick_speed, 0);
            end else begin
                want = expected_frames.pop_front();
                if (out_if.pressed_mask !== want.pressed_mask)
                    report_mismatch("pressed_mask", out_if.pressed_mask, want.pressed_mask);
                if (out_if.released_mask !== want.released_mask)
                    report_mismatch("released_mask", out_if.released_mask, want.released_mask);
                if (out_if.move_direction !== want.move_direction)
                    report_mismatch("move_direction", out_if.move_direction,
                                    want.move_direction);
                if (out_if.attack_direction !== want.attack_direction)
                    report_mismatch("attack_direction", out_if.attack_direction,
                                    want.attack_direction);
                if (out_if.push_direction !== want.push_direction)
                    report_mismatch("push_direction", out_if.push_direction,
                                    want.push_direction);
                if (out_if.flick_direction !== want.flick_direction)
                    report_mismatch("flick_direction", out_if.flick_direction,
                                    want.flick_direction);
                if (out_if.hard_push !== want.hard_push)
                    report_mismatch("hard_push", out_if.hard_push, want.hard_push);
                if (out_if.flick_speed !== want.flick_speed)
                    report_mismatch("flick_speed", out_if.flick_speed, want.flick_speed);
            end
            frames_checked++;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = REG_DEADZONE;
        i_cfg_data    = '0;
        in_if.valid   = 1'b0;
        in_if.left_x  = '0;
        in_if.left_y  = '0;
        in_if.right_x = '0;
        in_if.right_y = '0;
        in_if.buttons = '0;
        in_if.use_old = 1'b0;
        out_if.ready  = 1'b0;

        // predictor reset state
        cfg_dz       = DEADZONE_RST;
        cfg_thr      = DIR_THR_RST;
        prev_buttons = '0;
        last_left    = '0;
        for (int i = 0; i < HIST_LEN; i++) begin
            hist_x[i] = 0;
            hist_y[i] = 0;
        end

        tx_idle_en     = 1'b1;
        rx_idle_en     = 1'b1;
        rx_gap         = 0;
        rx_hold_cycles = 0;
        err_count      = 0;
        frames_sent    = 0;
        frames_checked = 0;
        settings_used  = 1;    // reset values
        fallback_hits  = 0;
        hard_hits      = 0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed_edges();
        test_register_extremes();
        test_random_gestures(120);
        test_output_backpressure();
        test_full_rate();

        drain(SETTLE_CYCLES);
        $display("%0d of %0d requests checked across %0d register settings",
                 frames_checked, frames_sent, settings_used);
        $display("flick fallbacks %0d, hard pushes %0d, mismatches %0d",
                 fallback_hits, hard_hits, err_count);
        if (err_count == 0 && expected_frames.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("timeout with %0d frames outstanding", expected_frames.size());
        $display("simulation failed");
        $finish;
    end

endmodule

/* joystick_flick_and_button_edge.f */
rtl/core/jfbe_pkg.sv
rtl/core/jfbe_in_if.sv
rtl/core/jfbe_out_if.sv
rtl/core/jfbe_isqrt.sv
rtl/core/jfbe_ctrl.sv
rtl/core/jfbe_dp.sv
rtl/core/joystick_flick_and_button_edge.sv
tb/tb_top.sv
